// ===== rtl/core/dhbq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhbq_pkg
// shared types and constants of the diagonal hsp / per-query best block
// ----------------------------------------------------------------------------
package dhbq_pkg;

   // request codes carried on req_tuser
   localparam logic REQ_SCORE = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   localparam int QUERY_W = 12;
   localparam int SCORE_W = 8;
   localparam int FIELD_W = 16;
   localparam int SUM_W   = 24;    // 65535 * 127 fits in 24 bits

   localparam logic [FIELD_W-1:0] MAX_DIAG_LEN = 16'd65535;
   localparam logic [FIELD_W-1:0] SCORE_CAP    = 16'd65534;

   // op queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   typedef enum logic {
      OP_CLEAR,
      OP_RESULT
   } op_kind_type;

   typedef struct packed {
      op_kind_type         kind;
      logic [QUERY_W-1:0]  query;
      logic [FIELD_W-1:0]  score;
      logic [FIELD_W-1:0]  start;
      logic [FIELD_W-1:0]  length;
   } op_type;

endpackage

// ===== rtl/core/diagonal_hsp_best_per_query_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diagonal_hsp_best_per_query_unit
// ungapped hsp search along diagonals with a per-query best-score table
// ----------------------------------------------------------------------------
// throughput: one item per cycle while req_tready is high, set by the running-sum
//   update and the read-modify-write of the table ram
// a result passes the op queue, the read stage and the output register in turn
// reset: diagonal state and queue clear at once; the table is then zeroed one
//   entry a cycle, during which req_tready stays low
// ----------------------------------------------------------------------------
module diagonal_hsp_best_per_query_unit
   import dhbq_pkg::*;
#(
   parameter int QUERY_COUNT = 4096
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // query_index[11:0], pair_score[19:12], zero pad
   input  logic        req_tuser,   // req_type: 0 score element, 1 clear query best
   input  logic        req_tlast,   // last_of_diagonal

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // result_query[11:0], hsp_score[27:12],
                                    // hsp_start[43:28], hsp_length[59:44],
                                    // query_best[75:60], first_hit[76],
                                    // improved[77], zero pad
);

   logic   accept;
   logic   push_valid;
   op_type push_op;
   logic   has_space;
   logic   head_valid;
   op_type head_op;
   logic   pop;
   logic   clearing;

   // front takes an item whenever the op queue has room and the table is ready
   assign req_tready = has_space && !clearing;
   assign accept     = req_tvalid && req_tready;

   // front: recurrence, one item a cycle while req_tready is high, pushes clear and result ops
   dhbq_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_kind         (req_tuser),
      .query_index      (req_tdata[11:0]),
      .pair_score       (req_tdata[19:12]),
      .last_of_diagonal (req_tlast),
      .push_valid       (push_valid),
      .push_op          (push_op)
   );

   // short queue lets the front keep going while the output is stalled
   dhbq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_op    (push_op),
      .pop        (pop),
      .has_space  (has_space),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   // back: table read, compare with forwarding, write, output register
   dhbq_back #(
      .QUERY_COUNT (QUERY_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/core/dhbq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhbq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module dhbq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/dhbq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhbq_front
// maximum-segment recurrence over one diagonal, emits table ops
// ----------------------------------------------------------------------------
module dhbq_front
   import dhbq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       req_kind,
   input  logic [QUERY_W-1:0]         query_index,
   input  logic signed [SCORE_W-1:0]  pair_score,
   input  logic                       last_of_diagonal,
   output logic                       push_valid,
   output op_type                     push_op
);

   logic [SUM_W-1:0]   running_sum_ff, running_sum_in;
   logic [SUM_W-1:0]   best_sum_ff, best_sum_in;
   logic [FIELD_W-1:0] position_ff, position_in;
   logic [FIELD_W-1:0] cur_len_ff, cur_len_in;
   logic [FIELD_W-1:0] suffix_ff, suffix_in;
   logic [FIELD_W-1:0] best_start_ff, best_start_in;
   logic [FIELD_W-1:0] best_len_ff, best_len_in;

   logic signed [SUM_W:0] f;
   logic                  take;
   logic                  gt_best;
   logic                  positive;
   logic [FIELD_W-1:0]    sat_score;
   logic                  score_item;

   assign score_item = accept && (req_kind == REQ_SCORE);

   always_comb begin
      f        = $signed({1'b0, running_sum_ff}) + (SUM_W+1)'(pair_score);
      take     = position_ff < MAX_DIAG_LEN;
      gt_best  = f > $signed({1'b0, best_sum_ff});
      positive = f > 0;

      running_sum_in = running_sum_ff;
      best_sum_in    = best_sum_ff;
      position_in    = position_ff;
      cur_len_in     = cur_len_ff;
      suffix_in      = suffix_ff;
      best_start_in  = best_start_ff;
      best_len_in    = best_len_ff;

      if (take) begin
         position_in = position_ff + 16'd1;
         if (gt_best) begin
            running_sum_in = f[SUM_W-1:0];
            best_sum_in    = f[SUM_W-1:0];
            best_start_in  = suffix_ff;
            cur_len_in     = cur_len_ff + 16'd1;
            best_len_in    = cur_len_ff + 16'd1;
         end else if (positive) begin
            running_sum_in = f[SUM_W-1:0];
            cur_len_in     = cur_len_ff + 16'd1;
         end else begin
            running_sum_in = '0;
            suffix_in      = position_ff + 16'd1;
            cur_len_in     = '0;
         end
      end

      // saturate the diagonal score
      if (best_sum_in > {{(SUM_W-FIELD_W){1'b0}}, SCORE_CAP}) begin
         sat_score = SCORE_CAP;
      end else begin
         sat_score = best_sum_in[FIELD_W-1:0];
      end

      push_valid     = accept && ((req_kind == REQ_CLEAR) || last_of_diagonal);
      push_op.kind   = (req_kind == REQ_CLEAR) ? OP_CLEAR : OP_RESULT;
      push_op.query  = query_index;
      push_op.score  = sat_score;
      push_op.start  = (sat_score != '0) ? best_start_in : '0;
      push_op.length = (sat_score != '0) ? best_len_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || (score_item && last_of_diagonal)) begin
         running_sum_ff <= '0;
         best_sum_ff    <= '0;
         position_ff    <= '0;
         cur_len_ff     <= '0;
         suffix_ff      <= '0;
         best_start_ff  <= '0;
         best_len_ff    <= '0;
      end else if (score_item) begin
         running_sum_ff <= running_sum_in;
         best_sum_ff    <= best_sum_in;
         position_ff    <= position_in;
         cur_len_ff     <= cur_len_in;
         suffix_ff      <= suffix_in;
         best_start_ff  <= best_start_in;
         best_len_ff    <= best_len_in;
      end
   end

endmodule

// ===== rtl/core/dhbq_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhbq_queue
// short show-ahead fifo of table ops between front and back
// ----------------------------------------------------------------------------
module dhbq_queue
   import dhbq_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   input  logic   pop,
   output logic   has_space,
   output logic   head_valid,
   output op_type head_op
);

   op_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;

   assign has_space  = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_op    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

endmodule

// ===== rtl/core/dhbq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhbq_back
// per-query best-score table update and result output register
// ----------------------------------------------------------------------------
module dhbq_back
   import dhbq_pkg::*;
#(
   parameter int QUERY_COUNT = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  op_type       head_op,
   output logic         pop,
   output logic         clearing,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata
);

   localparam int ADDR_W = $clog2(QUERY_COUNT);
   localparam int WIDE_W = 17;

   // clearing pass
   logic              clearing_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // read stage: op whose table word sits in the ram read register
   logic              s1_valid_ff;
   op_type            s1_op_ff;
   logic              s1_in_table_ff;
   logic [ADDR_W-1:0] s1_addr_ff;

   // last table write, forwarded to the op read at the same edge
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [FIELD_W-1:0] fwd_data_ff;

   // output register
   logic               rsp_valid_ff;
   logic [QUERY_W-1:0] out_query_ff;
   logic [FIELD_W-1:0] out_score_ff;
   logic [FIELD_W-1:0] out_start_ff;
   logic [FIELD_W-1:0] out_length_ff;
   logic [FIELD_W-1:0] out_best_ff;
   logic               out_first_ff;
   logic               out_impr_ff;

   logic [WIDE_W-1:0]  head_wide;
   logic [ADDR_W-1:0]  head_addr;
   logic               head_in_table;
   logic               advance;
   logic [FIELD_W-1:0] rd_data;
   logic [FIELD_W-1:0] old_best;
   logic [FIELD_W-1:0] new_best;
   logic [FIELD_W-1:0] rep_best;
   logic               first_hit;
   logic               improved;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [FIELD_W-1:0] wr_data;

   assign head_wide     = {{(WIDE_W-QUERY_W){1'b0}}, head_op.query};
   assign head_addr     = head_wide[ADDR_W-1:0];
   assign head_in_table = head_wide < WIDE_W'(QUERY_COUNT);

   assign advance  = !rsp_valid_ff || rsp_tready;
   assign pop      = advance && head_valid && !clearing_ff;
   assign clearing = clearing_ff;

   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         old_best = fwd_data_ff;
      end else begin
         old_best = rd_data;
      end

      first_hit = 1'b0;
      improved  = 1'b0;
      new_best  = old_best;
      rep_best  = '0;
      if (s1_op_ff.kind == OP_CLEAR) begin
         new_best = '0;
      end else if (s1_in_table_ff) begin
         rep_best = old_best;
         if (s1_op_ff.score != '0) begin
            first_hit = old_best == '0;
            improved  = s1_op_ff.score > old_best;
            if (improved) begin
               new_best = s1_op_ff.score;
               rep_best = s1_op_ff.score;
            end
         end
      end

      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = advance && s1_valid_ff && s1_in_table_ff;
         wr_addr = s1_addr_ff;
         wr_data = new_best;
      end
   end

   dhbq_ram #(
      .WIDTH (FIELD_W),
      .DEPTH (QUERY_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (pop),
      .rd_addr (head_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(QUERY_COUNT - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (advance) begin
            s1_valid_ff  <= pop;
            fwd_valid_ff <= s1_valid_ff && s1_in_table_ff && !clearing_ff;
            rsp_valid_ff <= s1_valid_ff && (s1_op_ff.kind == OP_RESULT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_op_ff       <= head_op;
         s1_in_table_ff <= head_in_table;
         s1_addr_ff     <= head_addr;
      end
      if (advance) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= new_best;
      end
      if (advance && s1_valid_ff) begin
         out_query_ff  <= s1_op_ff.query;
         out_score_ff  <= s1_op_ff.score;
         out_start_ff  <= s1_op_ff.start;
         out_length_ff <= s1_op_ff.length;
         out_best_ff   <= rep_best;
         out_first_ff  <= first_hit;
         out_impr_ff   <= improved;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, out_impr_ff, out_first_ff, out_best_ff, out_length_ff,
                        out_start_ff, out_score_ff, out_query_ff};

endmodule

// ===== test/tb_diagonal_hsp_best_per_query_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diagonal_hsp_best_per_query_unit
// self-checking bench for the diagonal hsp search and per-query best table
// ----------------------------------------------------------------------------
// streams diagonals of signed pair scores and clear requests into the block,
// keeps its own copy of the segment recurrence and of the best-score table,
// and compares every result item field by field against the oldest
// prediction; idle bursts on both sides, directed corner cases, saturation
// and a long random run
// ----------------------------------------------------------------------------
module tb_diagonal_hsp_best_per_query_unit;
   import dhbq_pkg::*;

   localparam int N_QUERIES   = 4096;
   // covers the table clearing pass after reset plus the longest idle bursts
   localparam int STALL_LIMIT = 20000;
   localparam int TAIL_CYCLES = 12;    // idle margin after the last expected result
   localparam int MAX_PRINTS  = 40;

   // one expected result item
   typedef struct {
      logic [QUERY_W-1:0] query;
      logic [FIELD_W-1:0] score;
      logic [FIELD_W-1:0] start;
      logic [FIELD_W-1:0] length;
      logic [FIELD_W-1:0] query_best;
      logic               first_hit;
      logic               improved;
   } hsp_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // query_index[11:0], pair_score[19:12], zero pad
   logic        req_tuser  = REQ_SCORE;   // req_type
   logic        req_tlast  = 1'b0;        // last_of_diagonal

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;   // result_query[11:0], hsp_score[27:12], hsp_start[43:28],
                             // hsp_length[59:44], query_best[75:60], first_hit[76],
                             // improved[77], zero pad

   diagonal_hsp_best_per_query_unit #(
      .QUERY_COUNT (N_QUERIES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor state: diagonal recurrence and the per-query best table
   // ------------------------------------------------------------------------
   int                 run_sum;
   int                 top_sum;
   int                 diag_pos;
   int                 suffix_len;
   int                 suffix_from;
   int                 top_from;
   int                 top_len;
   logic [FIELD_W-1:0] query_best_tab [N_QUERIES];

   hsp_report_type     hsp_reports_due[$];

   int  error_count    = 0;
   int  items_sent     = 0;
   int  clears_sent    = 0;
   int  results_seen   = 0;
   int  first_hits     = 0;
   int  improvements   = 0;
   int  saturated_hits = 0;
   int  quiet_cycles   = 0;
   bit  bursts_on      = 1'b0;
   int  ready_stall    = 0;

   logic [QUERY_W-1:0] query_pool [8];

   task automatic restart_diagonal();
      run_sum     = 0;
      top_sum     = 0;
      diag_pos    = 0;
      suffix_len  = 0;
      suffix_from = 0;
      top_from    = 0;
      top_len     = 0;
   endtask

   // one accepted item through the recurrence or the table clear; queues a report on a score item's last mark
   task automatic advance_hsp_search(input logic kind, input logic [QUERY_W-1:0] q,
                                     input logic [SCORE_W-1:0] raw, input logic last);
      int             grown;
      int             capped;
      logic [15:0]    prior;
      hsp_report_type rep;
      if (kind == REQ_CLEAR) begin
         // every 12-bit index lies inside the 4096-entry table
         query_best_tab[q] = '0;
         return;
      end
      // scores past the length limit are dropped, the last mark still counts
      if (diag_pos < int'(MAX_DIAG_LEN)) begin
         grown = run_sum + int'($signed(raw));
         if (grown > top_sum) begin
            run_sum    = grown;
            top_sum    = grown;
            top_from   = suffix_from;
            suffix_len = suffix_len + 1;
            top_len    = suffix_len;
         end else if (grown > 0) begin
            run_sum    = grown;
            suffix_len = suffix_len + 1;
         end else begin
            run_sum     = 0;
            suffix_from = diag_pos + 1;
            suffix_len  = 0;
         end
         diag_pos = diag_pos + 1;
      end
      if (!last) return;

      capped        = (top_sum > int'(SCORE_CAP)) ? int'(SCORE_CAP) : top_sum;
      prior         = query_best_tab[q];
      rep.query     = q;
      rep.score     = capped[15:0];
      rep.start     = (capped > 0) ? top_from[15:0] : '0;
      rep.length    = (capped > 0) ? top_len[15:0]  : '0;
      rep.query_best = prior;
      rep.first_hit = 1'b0;
      rep.improved  = 1'b0;
      if (capped > 0) begin
         if (prior == '0) begin
            rep.first_hit  = 1'b1;
            rep.improved   = 1'b1;
            rep.query_best = capped[15:0];
         end else if (capped > int'(prior)) begin
            rep.improved   = 1'b1;
            rep.query_best = capped[15:0];
         end
         query_best_tab[q] = rep.query_best;
      end
      hsp_reports_due = {hsp_reports_due, rep};
      restart_diagonal();
   endtask

   // ------------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------------
   task automatic send_item(input logic kind, input logic [QUERY_W-1:0] q,
                            input logic [SCORE_W-1:0] raw, input logic last);
      @(negedge clock);
      // occasional idle burst before the item
      if (bursts_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, raw, q};
      req_tuser  <= kind;
      req_tlast  <= last;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      items_sent++;
      if (kind == REQ_CLEAR) clears_sent++;
      advance_hsp_search(kind, q, raw, last);
   endtask

   task automatic hold_sender();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // sender pauses until every predicted result has come back
   task automatic drain_results();
      hold_sender();
      while (hsp_reports_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [SCORE_W-1:0] draw_pair_score(input int mode);
      int v;
      case (mode)
         0:       v = $urandom_range(0, 255) - 128;   // full range, every bit
         1:       v = $urandom_range(0, 16) - 8;      // small, segments come and go
         2:       v = $urandom_range(0, 24) - 6;      // leaning positive
         default: v = $urandom_range(0, 40) - 30;     // mostly negative
      endcase
      return v[7:0];
   endfunction

   function automatic logic [QUERY_W-1:0] draw_query();
      if ($urandom_range(0, 1) == 0) return query_pool[$urandom_range(0, 7)];
      return QUERY_W'($urandom_range(0, N_QUERIES - 1));
   endfunction

   // ------------------------------------------------------------------------
   // receiver side: random stall bursts on rsp_tready
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (ready_stall > 0) begin
         ready_stall <= ready_stall - 1;
         rsp_tready  <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
         ready_stall <= $urandom_range(1, 17) - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready  <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      hsp_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hsp_reports_due.size() == 0) begin
            report_mismatch("unexpected result item, query", rsp_tdata[11:0], -1);
         end else begin
            want = hsp_reports_due.pop_front();
            results_seen++;
            if (want.first_hit) first_hits++;
            if (want.improved) improvements++;
            if (want.score == SCORE_CAP) saturated_hits++;
            if (rsp_tdata[11:0] !== want.query)
               report_mismatch("result_query", rsp_tdata[11:0], want.query);
            if (rsp_tdata[27:12] !== want.score)
               report_mismatch("hsp_score", rsp_tdata[27:12], want.score);
            if (rsp_tdata[43:28] !== want.start)
               report_mismatch("hsp_start", rsp_tdata[43:28], want.start);
            if (rsp_tdata[59:44] !== want.length)
               report_mismatch("hsp_length", rsp_tdata[59:44], want.length);
            if (rsp_tdata[75:60] !== want.query_best)
               report_mismatch("query_best", rsp_tdata[75:60], want.query_best);
            if (rsp_tdata[76] !== want.first_hit)
               report_mismatch("first_hit", rsp_tdata[76], want.first_hit);
            if (rsp_tdata[77] !== want.improved)
               report_mismatch("improved", rsp_tdata[77], want.improved);
         end
      end
   end

   // watchdog on cycles where neither channel moves an item
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // field extremes, clears, ties and the zero-score case
   task automatic test_directed_cases();
      bursts_on = 1'b1;
      send_item(REQ_SCORE, 12'd0,    8'sd127,  1'b1);   // single element, first hit
      send_item(REQ_SCORE, 12'hFFF,  -8'sd128, 1'b1);   // nothing positive
      send_item(REQ_SCORE, 12'hFFF,  8'sd0,    1'b1);   // zero score as well
      // segment restarts after a dip below zero
      send_item(REQ_SCORE, 12'hFFF,  8'sd3,    1'b0);
      send_item(REQ_SCORE, 12'hFFF,  -8'sd5,   1'b0);
      send_item(REQ_SCORE, 12'hFFF,  8'sd4,    1'b0);
      send_item(REQ_SCORE, 12'hFFF,  8'sd4,    1'b0);
      send_item(REQ_SCORE, 12'hFFF,  -8'sd1,   1'b0);
      send_item(REQ_SCORE, 12'hFFF,  8'sd6,    1'b1);
      send_item(REQ_SCORE, 12'hFFF,  8'sd5,    1'b1);   // lower, best kept
      send_item(REQ_SCORE, 12'hFFF,  8'sd20,   1'b1);   // higher, best raised
      // clear in the middle of a diagonal leaves the diagonal alone
      send_item(REQ_SCORE, 12'd0,    8'sd10,   1'b0);
      send_item(REQ_CLEAR, 12'd0,    -8'sd128, 1'b1);
      send_item(REQ_SCORE, 12'd0,    8'sd20,   1'b1);
      // cleared query counts as a first hit again
      send_item(REQ_CLEAR, 12'hFFF,  8'sd127,  1'b0);
      send_item(REQ_SCORE, 12'hFFF,  8'sd1,    1'b1);
      send_item(REQ_SCORE, 12'hAAA,  -8'sd1,   1'b0);
      send_item(REQ_SCORE, 12'hAAA,  -8'sd1,   1'b0);
      send_item(REQ_SCORE, 12'hAAA,  8'sd2,    1'b1);
      // equal later segment does not move the best
      send_item(REQ_SCORE, 12'h555,  8'sd127,  1'b0);
      send_item(REQ_SCORE, 12'h555,  -8'sd128, 1'b0);
      send_item(REQ_SCORE, 12'h555,  8'sd127,  1'b1);
      drain_results();
   endtask

   // a long positive run drives the score past the cap
   task automatic test_score_saturation();
      bursts_on = 1'b1;
      for (int i = 0; i < 600; i++)
         send_item(REQ_SCORE, 12'h123, 8'sd127, i == 599);
      send_item(REQ_SCORE, 12'h123, 8'sd9, 1'b1);   // capped best stays
      drain_results();
   endtask

   // well-formed diagonals with random content, plus clears and noise
   task automatic test_random_diagonals(input int n_items, input bit with_bursts);
      int                 first_item;
      int                 len;
      int                 mode;
      bit                 paused;
      logic [QUERY_W-1:0] q;
      first_item = items_sent;
      paused     = 1'b0;
      bursts_on  = with_bursts;
      while (items_sent - first_item < n_items) begin
         if ($urandom_range(0, 99) < 8) begin
            send_item(REQ_CLEAR, draw_query(), draw_pair_score(0),
                      1'($urandom_range(0, 1)));
         end else begin
            q    = draw_query();
            mode = $urandom_range(0, 3);
            len  = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120)
                                                : $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
               // stray clear inside a diagonal
               if ($urandom_range(0, 29) == 0)
                  send_item(REQ_CLEAR, draw_query(), draw_pair_score(0),
                            1'($urandom_range(0, 1)));
               // the query of inner elements does not matter, vary it
               send_item(REQ_SCORE, (i == len - 1 || $urandom_range(0, 9) != 0) ? q
                         : draw_query(), draw_pair_score(mode), i == len - 1);
            end
         end
         if (!paused && items_sent - first_item >= n_items / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end
      drain_results();
   endtask

   initial begin
      for (int i = 0; i < N_QUERIES; i++) query_best_tab[i] = '0;
      restart_diagonal();
      query_pool[0] = 12'd0;
      query_pool[7] = 12'hFFF;
      for (int i = 1; i < 7; i++) query_pool[i] = QUERY_W'($urandom_range(0, N_QUERIES - 1));

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_score_saturation();
      test_random_diagonals(400, 1'b1);
      test_random_diagonals(80, 1'b0);   // closing stretch without idling

      hold_sender();
      while (hsp_reports_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d items (%0d clears), checked %0d diagonal results",
               items_sent, clears_sent, results_seen);
      $display("first hits %0d, best raised %0d, capped scores %0d",
               first_hits, improvements, saturated_hits);
      if (error_count == 0 && hsp_reports_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/dhbq_pkg.sv
rtl/core/dhbq_ram.sv
rtl/core/dhbq_front.sv
rtl/core/dhbq_queue.sv
rtl/core/dhbq_back.sv
rtl/core/diagonal_hsp_best_per_query_unit.sv
test/tb_diagonal_hsp_best_per_query_unit.sv
